FILE: src/pjt_pkg.sv
// Package for the permutation jump table engine: constants, operation codes,
// request and result types. No dependencies.
package pjt_pkg;
  localparam int unsigned MaxNDef = 1024;
  localparam int unsigned JumpDef = 32;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned CntW    = 11;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_SWAP  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [IdxW-1:0] position;
    logic [IdxW-1:0] partner;
    logic [IdxW-1:0] load_value;
    logic [CntW-1:0] step_count;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] reached;
    logic            bad_index;
  } res_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic            rd;
    logic [1:0]      rsel;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [1:0]      wsel;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] wdata;
  } mem_req_t;

  localparam logic [1:0] SelSucc = 2'd0;
  localparam logic [1:0] SelPred = 2'd1;
  localparam logic [1:0] SelJump = 2'd2;
endpackage

FILE: src/pjt_tables.sv
// Successor, predecessor and jump tables: three synchronous RAMs, each with one read and one write port.
// Depends on pjt_pkg.
module pjt_tables import pjt_pkg::*; (
  input  logic            clk,
  input  mem_req_t        req,
  output logic [IdxW-1:0] rdata
);
  localparam int unsigned AW = $clog2(MaxNDef);

  logic [IdxW-1:0] succ_mem [MaxNDef];
  logic [IdxW-1:0] pred_mem [MaxNDef];
  logic [IdxW-1:0] jump_mem [MaxNDef];
  logic [1:0]      sel_r;
  logic [IdxW-1:0] sd_r, pd_r, jd_r;
  logic [AW-1:0]   ra, wa;

  assign ra = AW'(req.raddr);
  assign wa = AW'(req.waddr);

  always_ff @(posedge clk) begin
    if (req.we && req.wsel == SelSucc) succ_mem[wa] <= req.wdata;
    if (req.we && req.wsel == SelPred) pred_mem[wa] <= req.wdata;
    if (req.we && req.wsel == SelJump) jump_mem[wa] <= req.wdata;
    if (req.rd) begin
      sd_r  <= succ_mem[ra];
      pd_r  <= pred_mem[ra];
      jd_r  <= jump_mem[ra];
      sel_r <= req.rsel;
    end
  end

  always_comb begin
    case (sel_r)
      SelSucc: rdata = sd_r;
      SelPred: rdata = pd_r;
      default: rdata = jd_r;
    endcase
  end
endmodule

FILE: src/pjt_seq.sv
// Sequencer: walks the tables one read at a time (request register, RAM read, capture).
// Depends on pjt_pkg.
module pjt_seq import pjt_pkg::*; #(
  parameter int unsigned JUMP  = JumpDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  req_t            in_req,
  input  logic [CntW-1:0] n_use,
  input  logic [IdxW-1:0] rdata,
  output logic            busy,
  output mem_req_t        mreq,
  output logic            res_vld,
  output res_t            res
);
  localparam int unsigned JW = $clog2(JUMP + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_B_ADV, S_B_ADVW, S_B_SUCCW, S_B_WR,
    S_W_RXW, S_W_RY, S_W_RYW, S_W_RPAW, S_W_RPB, S_W_RPBW,
    S_R_ADV, S_R_ADVW, S_R_WR, S_R_PPW, S_R_PFW,
    S_Q_RD, S_Q_RDW, S_DONE
  } st_t;

  st_t             st_r;
  logic [IdxW-1:0] i_r, p_r, far_r, x_r, y_r, sx_r, sy_r, pa_r;
  logic [CntW-1:0] steps_r;
  logic [JW-1:0]   j_r;
  logic            second_r;
  logic            res_vld_r;
  res_t            res_r;
  mem_req_t        mreq_r;
  logic            lat_r;
  logic            in_wait;

  function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] v);
    return IdxW'(32'(v) % MaxNDef);
  endfunction

  assign busy    = st_r != S_IDLE;
  assign mreq    = mreq_r;
  assign res_vld = res_vld_r;
  assign res     = res_r;

  // capture states wait while the RAM read completes
  assign in_wait = st_r inside {S_B_ADVW, S_B_SUCCW, S_W_RXW, S_W_RYW, S_W_RPAW,
                                S_W_RPBW, S_R_ADVW, S_R_PPW, S_R_PFW, S_Q_RDW};

  always_ff @(posedge clk) begin
    mreq_r.rd <= 1'b0;
    mreq_r.we <= 1'b0;
    res_vld_r <= 1'b0;
    if (!rst_n) begin
      st_r  <= S_IDLE;
      lat_r <= 1'b0;
    end else if (in_wait && !lat_r) begin
      lat_r <= 1'b1;
    end else begin
      lat_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          x_r <= in_req.position;
          y_r <= in_req.partner;
          steps_r <= in_req.step_count;
          unique case (op_t'(in_req.operation))
            OP_LOAD: begin
              if (CntW'(in_req.position) < n_use && CntW'(in_req.load_value) < n_use) begin
                mreq_r.we <= 1'b1; mreq_r.wsel <= SelSucc;
                mreq_r.waddr <= in_req.position; mreq_r.wdata <= in_req.load_value;
              end
              st_r <= S_DONE;
            end
            OP_BUILD: begin
              i_r <= '0; p_r <= '0; j_r <= '0; st_r <= S_B_ADV;
            end
            OP_SWAP: begin
              if (CntW'(in_req.position) < n_use && CntW'(in_req.partner) < n_use) begin
                mreq_r.rd <= 1'b1; mreq_r.rsel <= SelSucc;
                mreq_r.raddr <= in_req.position;
                st_r <= S_W_RXW;
              end else st_r <= S_DONE;
            end
            default: begin
              if (CntW'(in_req.position) >= n_use) begin
                res_vld_r <= 1'b1; res_r.reached <= '0; res_r.bad_index <= 1'b1;
                st_r <= S_DONE;
              end else st_r <= S_Q_RD;
            end
          endcase
        end
        // build: for each i walk JUMP successors, write jump[i], then set pred[succ[i]] = i
        S_B_ADV: begin
          if (CntW'(i_r) >= n_use) st_r <= S_DONE;
          else if (JW'(JUMP) == j_r) st_r <= S_B_WR;
          else begin
            mreq_r.rd <= 1'b1; mreq_r.rsel <= SelSucc; mreq_r.raddr <= slot(p_r);
            st_r <= S_B_ADVW;
          end
        end
        S_B_ADVW: begin p_r <= rdata; j_r <= j_r + 1'b1; st_r <= S_B_ADV; end
        S_B_WR: begin
          mreq_r.we <= 1'b1; mreq_r.wsel <= SelJump; mreq_r.waddr <= i_r;
          mreq_r.wdata <= p_r;
          mreq_r.rd <= 1'b1; mreq_r.rsel <= SelSucc; mreq_r.raddr <= i_r;
          st_r <= S_B_SUCCW;
        end
        S_B_SUCCW: begin
          mreq_r.we <= 1'b1; mreq_r.wsel <= SelPred; mreq_r.waddr <= slot(rdata);
          mreq_r.wdata <= i_r;
          i_r <= i_r + 1'b1; p_r <= i_r + 1'b1; j_r <= '0;
          st_r <= (CntW'(i_r) + 1'b1 >= n_use) ? S_DONE : S_B_ADV;
        end
        // swap
        S_W_RXW: begin
          sx_r <= rdata;
          mreq_r.rd <= 1'b1; mreq_r.rsel <= SelSucc; mreq_r.raddr <= y_r;
          st_r <= S_W_RYW;
        end
        S_W_RYW: begin
          sy_r <= rdata;
          mreq_r.we <= 1'b1; mreq_r.wsel <= SelSucc; mreq_r.waddr <= x_r;
          mreq_r.wdata <= rdata;
          st_r <= S_W_RY;
        end
        S_W_RY: begin
          mreq_r.we <= 1'b1; mreq_r.wsel <= SelSucc; mreq_r.waddr <= y_r;
          mreq_r.wdata <= sx_r;
          mreq_r.rd <= 1'b1; mreq_r.rsel <= SelPred; mreq_r.raddr <= slot(sy_r);
          st_r <= S_W_RPAW;
        end
        S_W_RPAW: begin
          pa_r <= rdata;
          mreq_r.rd <= 1'b1; mreq_r.rsel <= SelPred; mreq_r.raddr <= slot(sx_r);
          st_r <= S_W_RPBW;
        end
        S_W_RPBW: begin
          mreq_r.we <= 1'b1; mreq_r.wsel <= SelPred; mreq_r.waddr <= slot(sy_r);
          mreq_r.wdata <= rdata;
          st_r <= S_W_RPB;
        end
        S_W_RPB: begin
          mreq_r.we <= 1'b1; mreq_r.wsel <= SelPred; mreq_r.waddr <= slot(sx_r);
          mreq_r.wdata <= pa_r;
          second_r <= 1'b0; p_r <= x_r; far_r <= x_r; j_r <= '0;
          st_r <= S_R_ADV;
        end
        // repair: advance far, then JUMP writes walking predecessors
        S_R_ADV: begin
          if (JW'(JUMP) == j_r) begin j_r <= '0; st_r <= S_R_WR; end
          else begin
            mreq_r.rd <= 1'b1; mreq_r.rsel <= SelSucc; mreq_r.raddr <= slot(far_r);
            st_r <= S_R_ADVW;
          end
        end
        S_R_ADVW: begin far_r <= rdata; j_r <= j_r + 1'b1; st_r <= S_R_ADV; end
        S_R_WR: begin
          mreq_r.we <= 1'b1; mreq_r.wsel <= SelJump; mreq_r.waddr <= slot(p_r);
          mreq_r.wdata <= far_r;
          mreq_r.rd <= 1'b1; mreq_r.rsel <= SelPred; mreq_r.raddr <= slot(p_r);
          st_r <= S_R_PPW;
        end
        S_R_PPW: begin
          p_r <= rdata;
          mreq_r.rd <= 1'b1; mreq_r.rsel <= SelPred; mreq_r.raddr <= slot(far_r);
          st_r <= S_R_PFW;
        end
        S_R_PFW: begin
          far_r <= rdata;
          if (JW'(JUMP - 1) == j_r) begin
            if (second_r) st_r <= S_DONE;
            else begin
              second_r <= 1'b1; p_r <= y_r; far_r <= y_r; j_r <= '0;
              st_r <= S_R_ADV;
            end
          end else begin
            j_r <= j_r + 1'b1; st_r <= S_R_WR;
          end
        end
        // query
        S_Q_RD: begin
          if (steps_r == '0) begin
            res_vld_r <= 1'b1; res_r.reached <= x_r; res_r.bad_index <= 1'b0;
            st_r <= S_DONE;
          end else begin
            mreq_r.rd <= 1'b1; mreq_r.raddr <= slot(x_r);
            if (steps_r > CntW'(JUMP)) begin
              mreq_r.rsel <= SelJump; steps_r <= steps_r - CntW'(JUMP);
            end else begin
              mreq_r.rsel <= SelSucc; steps_r <= steps_r - 1'b1;
            end
            st_r <= S_Q_RDW;
          end
        end
        S_Q_RDW: begin x_r <= rdata; st_r <= S_Q_RD; end
        S_DONE:  st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/permutation_jump_table_engine_core.sv
// Top level of the permutation jump table engine: config register, sequencer,
// table memories. Depends on pjt_pkg, pjt_seq, pjt_tables.
//
// One request at a time; busy is high from the accepting edge until the
// request has finished. Every table read passes the request register, the
// synchronous RAM read and the capture, and only one read is in flight. A
// query makes up to steps/JUMP + JUMP reads, jumps plus single steps. Only a
// query gives a result: it appears for one cycle with out_valid, in the cycle
// before busy falls, and cannot be stalled.
module permutation_jump_table_engine_core import pjt_pkg::*; #(
  parameter int unsigned JUMP  = JumpDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  req_t                in_req,
  output logic                out_valid,
  output res_t                out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CntW-1:0]     cfg_data
);
  logic [CntW-1:0] n_use_r;
  logic [IdxW-1:0] rdata;
  mem_req_t        mreq;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_use_r <= CntW'(MaxNDef);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) n_use_r <= CntW'(1);
      else if (32'(cfg_data) > MaxNDef) n_use_r <= CntW'(MaxNDef);
      else n_use_r <= cfg_data;
    end
  end

  pjt_seq #(.JUMP(JUMP)) u_seq (
    .clk, .rst_n, .start, .in_req, .n_use(n_use_r), .rdata, .busy,
    .mreq, .res_vld(out_valid), .res(out_res)
  );

  pjt_tables u_tables (.clk, .req(mreq), .rdata);

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("result not followed by idle");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.bad_index) |-> out_res.reached == '0)
    else $error("bad index with nonzero position");
  a_nuse: assert property (@(posedge clk) disable iff (!rst_n)
    n_use_r != '0) else $error("n_in_use zero");
endmodule
